// File: sv/mvdt_pkg.sv
// Shared types and constants for the milli-value to decimal text block.
// No dependencies.
package mvdt_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int STAMP_WIDTH_DEF = 32;
  localparam int FRAC_DIGITS     = 3;

  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SKIP,
    ST_INT,
    ST_POINT,
    ST_FRAC,
    ST_NEWLINE
  } mvdt_state_t;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_DIGIT,
    SEL_POINT,
    SEL_NEWLINE
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      digit_shift;
    logic      out_load;
    char_sel_t char_sel;
  } mvdt_cmd_t;

  typedef struct packed {
    logic drop;
    logic neg;
    logic conv_done;
    logic top_zero;
    logic int_more;
    logic int_last;
    logic frac_last;
    logic out_free;
  } mvdt_status_t;

endpackage

// File: sv/mvdt_if.sv
// Request and character channel interfaces.
// Depends on mvdt_pkg for default widths.
interface mvdt_in_if import mvdt_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] milli_value;
  logic        [STAMP_WIDTH-1:0] stamp;

  modport source (output valid, output milli_value, output stamp, input ready);
  modport sink   (input valid, input milli_value, input stamp, output ready);
endinterface

interface mvdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// File: sv/mvdt_ctrl.sv
// Controller: sequences conversion and character emission.
// Depends on mvdt_pkg; talks to mvdt_dp through command and status structs.
module mvdt_ctrl import mvdt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mvdt_status_t status,
  output mvdt_cmd_t    cmd
);

  mvdt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load        = 1'b0;
    cmd.conv_step   = 1'b0;
    cmd.digit_shift = 1'b0;
    cmd.out_load    = 1'b0;
    cmd.char_sel    = SEL_DIGIT;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !status.drop) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) begin
          state_next = status.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        cmd.char_sel = SEL_MINUS;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (status.top_zero && status.int_more) begin
          cmd.digit_shift = 1'b1;
        end else begin
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.digit_shift = 1'b1;
          if (status.int_last) begin
            state_next = ST_POINT;
          end
        end
      end
      ST_POINT: begin
        cmd.char_sel = SEL_POINT;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.digit_shift = 1'b1;
          if (status.frac_last) begin
            state_next = ST_NEWLINE;
          end
        end
      end
      ST_NEWLINE: begin
        cmd.char_sel = SEL_NEWLINE;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mvdt_dp.sv
// Datapath: stamp filter, magnitude, shift-add-3 BCD conversion,
// digit shifter and output register. Depends on mvdt_pkg and the channel interfaces.
module mvdt_dp import mvdt_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mvdt_in_if.sink      in_req,
  mvdt_out_if.source   out_rsp,
  input  mvdt_cmd_t    cmd,
  output mvdt_status_t status
);

  localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam int BIT_W  = $clog2(VALUE_WIDTH);

  logic [STAMP_WIDTH-1:0] last_stamp;
  logic                   stamp_seen;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_W-1:0]       bit_cnt;
  logic [CNT_W-1:0]       dig_cnt;
  logic [3:0]             top_digit;
  logic                   out_valid;
  logic [7:0]             out_char;
  logic                   last_char;
  logic [7:0]             char_next;

  assign raw       = in_req.milli_value;
  assign mag_in    = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  assign top_digit = bcd[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_seen <= 1'b0;
    end else if (cmd.load) begin
      stamp_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_stamp <= in_req.stamp;
      neg        <= raw[VALUE_WIDTH-1];
      mag        <= mag_in;
      bcd        <= '0;
      bit_cnt    <= '0;
      dig_cnt    <= CNT_W'(NDIG);
    end else if (cmd.conv_step) begin
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_W'(1);
    end else if (cmd.digit_shift) begin
      bcd     <= {bcd[BCD_W-5:0], 4'h0};
      dig_cnt <= dig_cnt - CNT_W'(1);
    end
  end

  always_comb begin
    unique case (cmd.char_sel)
      SEL_MINUS:   char_next = CHAR_MINUS;
      SEL_DIGIT:   char_next = CHAR_ZERO + {4'h0, top_digit};
      SEL_POINT:   char_next = CHAR_POINT;
      SEL_NEWLINE: char_next = CHAR_NEWLINE;
      default:     char_next = CHAR_NEWLINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char  <= char_next;
      last_char <= (cmd.char_sel == SEL_NEWLINE);
    end
  end

  assign out_rsp.valid     = out_valid;
  assign out_rsp.out_char  = out_char;
  assign out_rsp.last_char = last_char;

  assign status.drop      = stamp_seen && (in_req.stamp == last_stamp);
  assign status.neg       = neg;
  assign status.conv_done = (bit_cnt == BIT_W'(VALUE_WIDTH - 1));
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.int_more  = (dig_cnt > CNT_W'(FRAC_DIGITS + 1));
  assign status.int_last  = (dig_cnt == CNT_W'(FRAC_DIGITS + 1));
  assign status.frac_last = (dig_cnt == CNT_W'(1));
  assign status.out_free  = !out_valid || out_rsp.ready;

endmodule

// File: sv/milli_value_to_decimal_text.sv
// Top level: signed thousandths to ASCII decimal text, one character per response.
// Depends on mvdt_pkg, mvdt_if, mvdt_ctrl and mvdt_dp.
//
//   channel   dir  payload                   role
//   in_req    in   milli_value, stamp        one measurement request
//   out_rsp   out  out_char, last_char       one text character
//
// Per request: accept, shift-add-3 conversion over all VALUE_WIDTH bits, suppression of
// leading zeros, then the characters in order: an optional minus sign, the integer digits,
// the point, the fraction digits and a newline.
// A request whose stamp matches the stored one is accepted and produces no output.
// Synchronous reset clears the controller, the stamp-seen flag and response valid.
// A stalled response holds the emitter; the newline may wait while the next request is taken.
module milli_value_to_decimal_text import mvdt_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mvdt_in_if.sink    in_req,
  mvdt_out_if.source out_rsp
);

  mvdt_cmd_t    cmd;
  mvdt_status_t status;
  logic         in_ready;

  assign in_req.ready = in_ready;

  mvdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mvdt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// File: tb/sv/tb_milli_value_to_decimal_text.sv
// Testbench for milli_value_to_decimal_text: drives measurement requests, predicts
// the decimal text of each new stamp and checks every character and its last flag.
// Depends on mvdt_pkg, mvdt_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_milli_value_to_decimal_text;
  import mvdt_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class decimal_text_board;
    text_char_t  pending_chars[$];
    logic [31:0] last_stamp;
    bit          stamp_seen;
    int          mismatches;
    int          chars_checked;
    int          texts_formatted;
    int          repeats_dropped;

    function new();
      last_stamp      = '0;
      stamp_seen      = 1'b0;
      mismatches      = 0;
      chars_checked   = 0;
      texts_formatted = 0;
      repeats_dropped = 0;
    endfunction

    function void push_char(logic [7:0] ch, logic last);
      text_char_t c;
      c.ch   = ch;
      c.last = last;
      pending_chars.push_back(c);
    endfunction

    function void note_request(logic signed [31:0] value, logic [31:0] stamp);
      logic [31:0] mag;
      logic [31:0] ipart;
      logic [31:0] fpart;
      logic [7:0]  digits[$];
      if (stamp_seen && stamp == last_stamp) begin
        repeats_dropped++;
        return;
      end
      last_stamp = stamp;
      stamp_seen = 1'b1;
      texts_formatted++;
      if (value[31]) begin
        push_char(CHAR_MINUS, 1'b0);
        mag = ~value + 32'd1;
      end else begin
        mag = value;
      end
      ipart = mag / 32'd1000;
      fpart = mag % 32'd1000;
      do begin
        digits.push_front(8'(CHAR_ZERO + ipart % 32'd10));
        ipart = ipart / 32'd10;
      end while (ipart != 0);
      foreach (digits[i]) push_char(digits[i], 1'b0);
      push_char(CHAR_POINT, 1'b0);
      push_char(8'(CHAR_ZERO + fpart / 32'd100), 1'b0);
      push_char(8'(CHAR_ZERO + (fpart / 32'd10) % 32'd10), 1'b0);
      push_char(8'(CHAR_ZERO + fpart % 32'd10), 1'b0);
      push_char(CHAR_NEWLINE, 1'b1);
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character expected none actual %h last %b", $time, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        mismatches++;
        $display("%0t: out_char mismatch expected %h actual %h", $time, want.ch, ch);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: last_char mismatch expected %b actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mvdt_in_if  in_req ();
  mvdt_out_if out_rsp ();

  milli_value_to_decimal_text dut (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  decimal_text_board board = new();

  bit          send_gaps;
  bit          rsp_gaps;
  bit          hold_rsp;
  bit          stamp_sent;
  logic [31:0] prev_stamp;
  int          sent_requests;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_req.valid && in_req.ready) begin
      board.note_request(in_req.milli_value, in_req.stamp);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_rsp.valid && out_rsp.ready) begin
      board.check_char(out_rsp.out_char, out_rsp.last_char);
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        out_rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
        out_rsp.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic signed [31:0] value, input logic [31:0] stamp);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.milli_value <= value;
    in_req.stamp       <= stamp;
    do @(posedge clk); while (!in_req.ready);
    sent_requests++;
    stamp_sent = 1'b1;
    prev_stamp = stamp;
  endtask

  task automatic send_fresh(input logic signed [31:0] value);
    logic [31:0] s;
    do s = $urandom; while (stamp_sent && s == prev_stamp);
    send_request(value, s);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    int unsigned        scale;
    scale = 1;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 20000)) - 10000;
      2: v = $signed($urandom_range(0, 1998)) - 999;
      3: begin
        repeat ($urandom_range(0, 6)) scale = scale * 10;
        v = $signed(scale * 1000) + $signed($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sh8000_0001;
          default: v = 0;
        endcase
      end
      default: begin
        v = $signed($urandom_range(0, 999999));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    rst                = 1'b1;
    in_req.valid       = 1'b0;
    in_req.milli_value = '0;
    in_req.stamp       = '0;
    send_gaps          = 1'b1;
    rsp_gaps           = 1'b1;
    hold_rsp           = 1'b0;
    stamp_sent         = 1'b0;
    prev_stamp         = '0;
    sent_requests      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first request with stamp 0 must still be formatted; repeat is dropped
    send_request(0, 32'd0);
    send_request(12345, 32'd0);
    send_request(32'sh8000_0000, 32'd1);
    send_request(32'sh7FFF_FFFF, 32'd2);
    send_request(-2147483647, 32'd3);
    send_request(-500, 32'd4);
    send_request(500, 32'd5);
    send_request(999, 32'd6);
    send_request(1000, 32'd7);
    send_request(-1000, 32'd8);
    send_request(1, 32'd9);
    send_request(-1, 32'd10);
    send_request(999999, 32'd11);
    send_request(-999999, 32'd12);
    send_request(1000000000, 32'd13);
    send_request(-1000000, 32'd14);
    send_request(777, 32'd14);
    send_request(42, 32'hFFFF_FFFF);
    send_request(43, 32'hFFFF_FFFF);
    send_request(-42, 32'd0);

    // long response hold-off while requests keep coming
    send_gaps = 1'b0;
    hold_rsp  = 1'b1;
    repeat (8) send_fresh(pick_value());
    send_gaps = 1'b1;

    while (sent_requests < 360) begin
      if (sent_requests == 300) begin
        send_gaps = 1'b0;
        rsp_gaps  = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) send_request(pick_value(), prev_stamp);
      else send_fresh(pick_value());
    end
    in_req.valid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Formatted %0d requests, dropped %0d repeated stamps, checked %0d characters.",
             board.texts_formatted, board.repeats_dropped, board.chars_checked);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d characters outstanding", board.pending_chars.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: milli_value_to_decimal_text.f
sv/mvdt_pkg.sv
sv/mvdt_if.sv
sv/mvdt_ctrl.sv
sv/mvdt_dp.sv
sv/milli_value_to_decimal_text.sv
tb/sv/tb_milli_value_to_decimal_text.sv
